/* design/multicolor_bitmap_to_rgb_macros.svh */
// ---------------------------------------------------------------------------
// multicolor_bitmap_to_rgb_macros.svh
// assertion macros used by the pixel decoder rtl
// ---------------------------------------------------------------------------
`ifndef MULTICOLOR_BITMAP_TO_RGB_MACROS_SVH
`define MULTICOLOR_BITMAP_TO_RGB_MACROS_SVH

// plain property, checked out of reset
`define MCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MCB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/mcb2rgb_pkg.sv */
// ---------------------------------------------------------------------------
// mcb2rgb_pkg
// types, palette tables and fixed-point helpers for the multicolour decoder
// ---------------------------------------------------------------------------
package mcb2rgb_pkg;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [7:0] video_byte;
    logic [7:0] color_byte;
    logic [5:0] card_column;
    logic [4:0] card_row;
    logic [2:0] line_in_card;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [3:0] angle;
    logic [5:0] luma;
    logic       chroma;
  } pal_entry_t;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 2'd1;
  localparam logic [3:0]  BG_RESET   = 4'd0;
  localparam logic [11:0] GAIN_RESET = 12'd256;

  // pixel codes
  localparam logic [1:0] CODE_BACKGROUND = 2'd0;
  localparam logic [1:0] CODE_VIDEO_HI   = 2'd1;
  localparam logic [1:0] CODE_VIDEO_LO   = 2'd2;
  localparam logic [1:0] CODE_COLOR      = 2'd3;

  // fixed point: 0.1331 and the yuv->rgb coefficients in Q16
  localparam logic [13:0] SCALE_Q16 = 14'd8723;
  localparam longint COEF_RV = 74700;
  localparam longint COEF_GU = 25864;
  localparam longint COEF_GV = 38050;
  localparam longint COEF_BU = 133176;

  localparam int A_W   = 18;  // chroma amplitude, max 139534
  localparam int K_W   = 35;  // per-entry chroma coefficient, signed
  localparam int KL_W  = 17;  // low part of the split coefficient
  localparam int PL_W  = A_W + KL_W;
  localparam int PH_W  = A_W + 1 + (K_W - KL_W);
  localparam int SUM_W = 56;
  localparam int CLP_W = 49;  // clamped channel, 0..2^48
  localparam int SCL_W = 57;

  function automatic pal_entry_t pal_lookup(input logic [3:0] idx);
    pal_entry_t e;
    case (idx)
      4'd0:    e = '{4'd0,  6'd0,  1'b0};
      4'd1:    e = '{4'd0,  6'd32, 1'b0};
      4'd2:    e = '{4'd5,  6'd10, 1'b1};
      4'd3:    e = '{4'd13, 6'd20, 1'b1};
      4'd4:    e = '{4'd2,  6'd12, 1'b1};
      4'd5:    e = '{4'd10, 6'd16, 1'b1};
      4'd6:    e = '{4'd0,  6'd8,  1'b1};
      4'd7:    e = '{4'd8,  6'd24, 1'b1};
      4'd8:    e = '{4'd6,  6'd12, 1'b1};
      4'd9:    e = '{4'd7,  6'd8,  1'b1};
      4'd10:   e = '{4'd5,  6'd16, 1'b1};
      4'd11:   e = '{4'd0,  6'd10, 1'b0};
      4'd12:   e = '{4'd0,  6'd15, 1'b0};
      4'd13:   e = '{4'd10, 6'd24, 1'b1};
      4'd14:   e = '{4'd0,  6'd15, 1'b1};
      default: e = '{4'd0,  6'd20, 1'b0};
    endcase
    return e;
  endfunction

  // cos(k*pi/8) in Q16
  function automatic longint cos_q16(input logic [3:0] k);
    longint c;
    case (k)
      4'd0:    c = 65536;
      4'd1:    c = 60547;
      4'd2:    c = 46341;
      4'd3:    c = 25080;
      4'd4:    c = 0;
      4'd5:    c = -25080;
      4'd6:    c = -46341;
      4'd7:    c = -60547;
      4'd8:    c = -65536;
      4'd9:    c = -60547;
      4'd10:   c = -46341;
      4'd11:   c = -25080;
      4'd12:   c = 0;
      4'd13:   c = 25080;
      4'd14:   c = 46341;
      default: c = 60547;
    endcase
    return c;
  endfunction

  // coefficient times the amplitude gives the chroma term of a channel in Q48
  function automatic logic signed [K_W-1:0] k_red(input logic [3:0] idx);
    pal_entry_t e;
    longint     cv;
    e  = pal_lookup(idx);
    cv = cos_q16(e.angle + 4'd12);
    return e.chroma ? K_W'(COEF_RV * cv) : '0;
  endfunction

  function automatic logic signed [K_W-1:0] k_green(input logic [3:0] idx);
    pal_entry_t e;
    longint     cu;
    longint     cv;
    e  = pal_lookup(idx);
    cu = cos_q16(e.angle);
    cv = cos_q16(e.angle + 4'd12);
    return e.chroma ? K_W'(-(COEF_GU * cu) - COEF_GV * cv) : '0;
  endfunction

  function automatic logic signed [K_W-1:0] k_blue(input logic [3:0] idx);
    pal_entry_t e;
    longint     cu;
    e  = pal_lookup(idx);
    cu = cos_q16(e.angle);
    return e.chroma ? K_W'(COEF_BU * cu) : '0;
  endfunction

  // luma<<43 plus the two partial products of the chroma term
  function automatic logic signed [SUM_W-1:0] chan_sum(
    input logic [5:0]             luma,
    input logic [PL_W-1:0]        pl,
    input logic signed [PH_W-1:0] ph
  );
    logic signed [SUM_W-1:0] y48;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    y48 = {{(SUM_W-6-43){1'b0}}, luma, 43'd0};
    hi  = {{(SUM_W-PH_W-KL_W){ph[PH_W-1]}}, ph, {KL_W{1'b0}}};
    lo  = {{(SUM_W-PL_W){1'b0}}, pl};
    return y48 + hi + lo;
  endfunction

  function automatic logic [CLP_W-1:0] chan_clamp(input logic signed [SUM_W-1:0] s);
    logic [CLP_W-1:0] r;
    if (s[SUM_W-1] || (s == '0)) begin
      r = '0;
    end else if (s[SUM_W-2:CLP_W-1] != '0) begin
      r = {1'b1, {(CLP_W-1){1'b0}}};
    end else begin
      r = s[CLP_W-1:0];
    end
    return r;
  endfunction

  // (255*x + 2^47) >> 48
  function automatic logic [7:0] chan_round(input logic [CLP_W-1:0] x);
    logic [SCL_W-1:0] t;
    t = {x, 8'd0} - {8'd0, x} + {9'd0, 1'b1, 47'd0};
    return t[55:48];
  endfunction

endpackage

/* design/multicolor_bitmap_to_rgb.sv */
// ---------------------------------------------------------------------------
// multicolor_bitmap_to_rgb
// multicolour bitmap byte to four rgb pixels through a fixed yuv palette
// throughput: one pixel per cycle while out_stall is low; the four-pixel serialiser in
//   front of a five-stage pipeline takes a new byte only as it hands on the last pixel
//   of the byte before
// reset: synchronous active-low; empties the pipeline, background 0, gain 1.0
// ---------------------------------------------------------------------------
module multicolor_bitmap_to_rgb #(
  parameter int CARD_COLUMNS = 40,
  parameter int CARD_ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mcb2rgb_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mcb2rgb_pkg::out_item_t              out_data,
  input  logic                                cfg_we,
  input  logic [mcb2rgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcb2rgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "multicolor_bitmap_to_rgb_macros.svh"

  localparam logic [5:0] COL_MAX = 6'(CARD_COLUMNS - 1);
  localparam logic [5:0] ROW_MAX = 6'(CARD_ROWS - 1);

  // configuration
  logic [3:0]                  bg_r;
  logic [11:0]                 gain_r;
  logic [mcb2rgb_pkg::A_W-1:0] amp_r;
  logic [25:0]                 amp_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r   <= mcb2rgb_pkg::BG_RESET;
      gain_r <= mcb2rgb_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mcb2rgb_pkg::CFG_BACKGROUND: bg_r   <= cfg_data[3:0];
        mcb2rgb_pkg::CFG_SATURATION: gain_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // chroma amplitude follows the gain in the next cycle
  assign amp_prod = gain_r * mcb2rgb_pkg::SCALE_Q16 + 26'd128;

  always_ff @(posedge clk) begin
    amp_r <= amp_prod[25:8];
  end

  // whole pipeline moves when the output register can take a new pixel
  logic out_valid_r;
  logic adv;
  assign adv = !out_valid_r || !out_stall;

  // stage 0: byte holder and pixel serialiser
  logic       s0_valid_r;
  logic       s0_valid_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [7:0] s0_bits_r;
  logic [7:0] s0_video_r;
  logic [3:0] s0_color_r;
  logic [5:0] s0_col_r;
  logic [7:0] s0_y_r;
  logic       in_take;
  logic       byte_done;
  logic [5:0] col_c;
  logic [5:0] row_c;
  logic [1:0] code;
  logic [3:0] idx;
  mcb2rgb_pkg::pal_entry_t pal_e;

  assign byte_done = s0_valid_r && adv && (cnt_r == 2'd3);
  assign in_stall  = s0_valid_r && !byte_done;
  assign in_take   = in_valid && !in_stall;

  assign col_c = (in_data.card_column > COL_MAX) ? COL_MAX : in_data.card_column;
  assign row_c = ({1'b0, in_data.card_row} > ROW_MAX) ? ROW_MAX : {1'b0, in_data.card_row};

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    cnt_nxt      = cnt_r;
    if (s0_valid_r && adv) begin
      cnt_nxt = cnt_r + 2'd1;
    end
    if (byte_done) begin
      s0_valid_nxt = 1'b0;
    end
    if (in_take) begin
      s0_valid_nxt = 1'b1;
      cnt_nxt      = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_bits_r  <= in_data.pixel_byte;
      s0_video_r <= in_data.video_byte;
      s0_color_r <= in_data.color_byte[3:0];
      s0_col_r   <= col_c;
      s0_y_r     <= {row_c[4:0], in_data.line_in_card};
    end
  end

  always_comb begin
    case (cnt_r)
      2'd0:    code = s0_bits_r[7:6];
      2'd1:    code = s0_bits_r[5:4];
      2'd2:    code = s0_bits_r[3:2];
      default: code = s0_bits_r[1:0];
    endcase
    case (code)
      mcb2rgb_pkg::CODE_BACKGROUND: idx = bg_r;
      mcb2rgb_pkg::CODE_VIDEO_HI:   idx = s0_video_r[7:4];
      mcb2rgb_pkg::CODE_VIDEO_LO:   idx = s0_video_r[3:0];
      default:                      idx = s0_color_r;
    endcase
  end

  assign pal_e = mcb2rgb_pkg::pal_lookup(idx);

  // stage 1: palette lookup
  logic                               s1_valid_r;
  logic [7:0]                         s1_x_r;
  logic [7:0]                         s1_y_r;
  logic                               s1_last_r;
  logic [5:0]                         s1_luma_r;
  logic signed [mcb2rgb_pkg::K_W-1:0] s1_kr_r;
  logic signed [mcb2rgb_pkg::K_W-1:0] s1_kg_r;
  logic signed [mcb2rgb_pkg::K_W-1:0] s1_kb_r;

  // stage 2: split products of amplitude and coefficient
  logic                                s2_valid_r;
  logic [7:0]                          s2_x_r;
  logic [7:0]                          s2_y_r;
  logic                                s2_last_r;
  logic [5:0]                          s2_luma_r;
  logic [mcb2rgb_pkg::PL_W-1:0]        s2_plr_r;
  logic [mcb2rgb_pkg::PL_W-1:0]        s2_plg_r;
  logic [mcb2rgb_pkg::PL_W-1:0]        s2_plb_r;
  logic signed [mcb2rgb_pkg::PH_W-1:0] s2_phr_r;
  logic signed [mcb2rgb_pkg::PH_W-1:0] s2_phg_r;
  logic signed [mcb2rgb_pkg::PH_W-1:0] s2_phb_r;
  logic signed [mcb2rgb_pkg::A_W:0]    amp_s;

  // stage 3: channel sums in Q48
  logic                                 s3_valid_r;
  logic [7:0]                           s3_x_r;
  logic [7:0]                           s3_y_r;
  logic                                 s3_last_r;
  logic signed [mcb2rgb_pkg::SUM_W-1:0] s3_r_r;
  logic signed [mcb2rgb_pkg::SUM_W-1:0] s3_g_r;
  logic signed [mcb2rgb_pkg::SUM_W-1:0] s3_b_r;

  // stage 4: clamped to 0..1
  logic                          s4_valid_r;
  logic [7:0]                    s4_x_r;
  logic [7:0]                    s4_y_r;
  logic                          s4_last_r;
  logic [mcb2rgb_pkg::CLP_W-1:0] s4_r_r;
  logic [mcb2rgb_pkg::CLP_W-1:0] s4_g_r;
  logic [mcb2rgb_pkg::CLP_W-1:0] s4_b_r;

  mcb2rgb_pkg::out_item_t out_r;

  assign amp_s = $signed({1'b0, amp_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r    <= {s0_col_r, cnt_r};
      s1_y_r    <= s0_y_r;
      s1_last_r <= (cnt_r == 2'd3);
      s1_luma_r <= pal_e.luma;
      s1_kr_r   <= mcb2rgb_pkg::k_red(idx);
      s1_kg_r   <= mcb2rgb_pkg::k_green(idx);
      s1_kb_r   <= mcb2rgb_pkg::k_blue(idx);

      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_last_r <= s1_last_r;
      s2_luma_r <= s1_luma_r;
      s2_plr_r  <= amp_r * s1_kr_r[mcb2rgb_pkg::KL_W-1:0];
      s2_plg_r  <= amp_r * s1_kg_r[mcb2rgb_pkg::KL_W-1:0];
      s2_plb_r  <= amp_r * s1_kb_r[mcb2rgb_pkg::KL_W-1:0];
      s2_phr_r  <= amp_s * $signed(s1_kr_r[mcb2rgb_pkg::K_W-1:mcb2rgb_pkg::KL_W]);
      s2_phg_r  <= amp_s * $signed(s1_kg_r[mcb2rgb_pkg::K_W-1:mcb2rgb_pkg::KL_W]);
      s2_phb_r  <= amp_s * $signed(s1_kb_r[mcb2rgb_pkg::K_W-1:mcb2rgb_pkg::KL_W]);

      s3_x_r    <= s2_x_r;
      s3_y_r    <= s2_y_r;
      s3_last_r <= s2_last_r;
      s3_r_r    <= mcb2rgb_pkg::chan_sum(s2_luma_r, s2_plr_r, s2_phr_r);
      s3_g_r    <= mcb2rgb_pkg::chan_sum(s2_luma_r, s2_plg_r, s2_phg_r);
      s3_b_r    <= mcb2rgb_pkg::chan_sum(s2_luma_r, s2_plb_r, s2_phb_r);

      s4_x_r    <= s3_x_r;
      s4_y_r    <= s3_y_r;
      s4_last_r <= s3_last_r;
      s4_r_r    <= mcb2rgb_pkg::chan_clamp(s3_r_r);
      s4_g_r    <= mcb2rgb_pkg::chan_clamp(s3_g_r);
      s4_b_r    <= mcb2rgb_pkg::chan_clamp(s3_b_r);

      out_r.pixel_x    <= s4_x_r;
      out_r.pixel_y    <= s4_y_r;
      out_r.last_pixel <= s4_last_r;
      out_r.red        <= mcb2rgb_pkg::chan_round(s4_r_r);
      out_r.green      <= mcb2rgb_pkg::chan_round(s4_g_r);
      out_r.blue       <= mcb2rgb_pkg::chan_round(s4_b_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MCB_ASSERT_NEXT(a_take_starts_byte, in_valid && !in_stall, s0_valid_r && (cnt_r == 2'd0), "accepted byte did not start at pixel zero")
  `MCB_ASSERT_IMPL(a_empty_not_stalled, !s0_valid_r, !in_stall, "input stalled with an empty serialiser")
  `MCB_ASSERT_NEXT(a_freeze_on_stall, out_valid_r && out_stall, $stable(s4_valid_r) && $stable(s1_valid_r), "pipeline moved while output was held")
  `MCB_ASSERT(a_last_at_fourth, !out_valid_r || (out_r.last_pixel == (out_r.pixel_x[1:0] == 2'd3)), "last pixel flag out of step with pixel column")

endmodule

/* tb/multicolor_bitmap_to_rgb_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multicolor_bitmap_to_rgb_checker
// watches the byte, pixel and register ports of the multicolour decoder,
// works out the four rgb pixels of every byte taken and compares each pixel
// the block hands over with the oldest one still awaited
// ---------------------------------------------------------------------------
module multicolor_bitmap_to_rgb_checker #(
  parameter int CARD_COLUMNS = 40,
  parameter int CARD_ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  mcb2rgb_pkg::in_item_t               in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  mcb2rgb_pkg::out_item_t              out_data,
  input  logic                                cfg_we,
  input  logic [mcb2rgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcb2rgb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  pixels_checked
);

  // Q16 constants: 0.1331 and the yuv to rgb weights
  localparam longint TINT_SCALE = 8723;
  localparam longint RED_V      = 74700;
  localparam longint GREEN_U    = 25864;
  localparam longint GREEN_V    = 38050;
  localparam longint BLUE_U     = 133176;
  localparam longint FULL_SCALE = longint'(1) << 48;
  localparam longint HALF_STEP  = longint'(1) << 47;
  localparam int     REPORT_MAX = 10;

  logic [3:0]             bg_index;
  logic [11:0]            gain;
  mcb2rgb_pkg::out_item_t pixels_due[$];

  // hue, luma and tint flag of each of the sixteen colours
  function automatic logic [10:0] colour_entry(input logic [3:0] colour);
    logic [10:0] e;
    case (colour)
      4'd0:    e = {4'd0,  6'd0,  1'b0};
      4'd1:    e = {4'd0,  6'd32, 1'b0};
      4'd2:    e = {4'd5,  6'd10, 1'b1};
      4'd3:    e = {4'd13, 6'd20, 1'b1};
      4'd4:    e = {4'd2,  6'd12, 1'b1};
      4'd5:    e = {4'd10, 6'd16, 1'b1};
      4'd6:    e = {4'd0,  6'd8,  1'b1};
      4'd7:    e = {4'd8,  6'd24, 1'b1};
      4'd8:    e = {4'd6,  6'd12, 1'b1};
      4'd9:    e = {4'd7,  6'd8,  1'b1};
      4'd10:   e = {4'd5,  6'd16, 1'b1};
      4'd11:   e = {4'd0,  6'd10, 1'b0};
      4'd12:   e = {4'd0,  6'd15, 1'b0};
      4'd13:   e = {4'd10, 6'd24, 1'b1};
      4'd14:   e = {4'd0,  6'd15, 1'b1};
      default: e = {4'd0,  6'd20, 1'b0};
    endcase
    return e;
  endfunction

  // cosine of step*pi/8 in Q16
  function automatic longint cosine(input logic [3:0] step);
    longint c;
    case (step)
      4'd0:    c = 65536;
      4'd1:    c = 60547;
      4'd2:    c = 46341;
      4'd3:    c = 25080;
      4'd4:    c = 0;
      4'd5:    c = -25080;
      4'd6:    c = -46341;
      4'd7:    c = -60547;
      4'd8:    c = -65536;
      4'd9:    c = -60547;
      4'd10:   c = -46341;
      4'd11:   c = -25080;
      4'd12:   c = 0;
      4'd13:   c = 25080;
      4'd14:   c = 46341;
      default: c = 60547;
    endcase
    return c;
  endfunction

  // Q48 channel clamped to 0..1, then rounded half up to 0..255
  function automatic logic [7:0] intensity(input longint acc);
    if (acc <= 0) return 8'd0;
    if (acc >= FULL_SCALE) return 8'd255;
    return 8'((acc * 255 + HALF_STEP) >>> 48);
  endfunction

  function automatic mcb2rgb_pkg::out_item_t shade_pixel(
    input logic [3:0]  colour,
    input logic [11:0] chroma_gain,
    input logic [7:0]  x,
    input logic [7:0]  y,
    input logic        last
  );
    logic [3:0]             hue;
    logic [5:0]             luma;
    logic                   tinted;
    longint                 amp;
    longint                 u;
    longint                 v;
    longint                 y48;
    mcb2rgb_pkg::out_item_t px;
    {hue, luma, tinted} = colour_entry(colour);
    y48 = longint'(luma) << 43;
    u   = 0;
    v   = 0;
    if (tinted) begin
      amp = (longint'(chroma_gain) * TINT_SCALE + 128) >>> 8;
      u   = amp * cosine(hue);
      v   = amp * cosine(4'(hue + 4'd12));
    end
    px.pixel_x    = x;
    px.pixel_y    = y;
    px.red        = intensity(y48 + RED_V * v);
    px.green      = intensity(y48 - GREEN_U * u - GREEN_V * v);
    px.blue       = intensity(y48 + BLUE_U * u);
    px.last_pixel = last;
    return px;
  endfunction

  task automatic note_failure(input string what, input mcb2rgb_pkg::out_item_t want,
                              input mcb2rgb_pkg::out_item_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected x=%0d y=%0d rgb=%0d,%0d,%0d last=%0b",
               want.pixel_x, want.pixel_y, want.red, want.green, want.blue, want.last_pixel);
      $display("  actual   x=%0d y=%0d rgb=%0d,%0d,%0d last=%0b",
               got.pixel_x, got.pixel_y, got.red, got.green, got.blue, got.last_pixel);
    end
  endtask

  always @(posedge clk) begin : watch
    mcb2rgb_pkg::out_item_t want;
    logic [1:0]             code;
    logic [3:0]             colour;
    int                     col;
    int                     row;
    int                     p;
    if (!rst_n) begin
      bg_index = mcb2rgb_pkg::BG_RESET;
      gain     = mcb2rgb_pkg::GAIN_RESET;
      pixels_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mcb2rgb_pkg::CFG_BACKGROUND: bg_index = cfg_data[3:0];
          mcb2rgb_pkg::CFG_SATURATION: gain     = cfg_data[11:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        pixels_checked++;
        if (pixels_due.size() == 0) begin
          note_failure("pixel with none awaited", '0, out_data);
        end else begin
          want = pixels_due.pop_front();
          if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
              out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue || out_data.last_pixel !== want.last_pixel) begin
            note_failure("pixel mismatch", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        // positions past the screen edge stick to the last card
        col = (in_data.card_column >= CARD_COLUMNS) ? CARD_COLUMNS - 1 : in_data.card_column;
        row = (in_data.card_row >= CARD_ROWS) ? CARD_ROWS - 1 : in_data.card_row;
        for (p = 0; p < 4; p++) begin
          code = 2'(in_data.pixel_byte >> (6 - 2 * p));
          case (code)
            mcb2rgb_pkg::CODE_BACKGROUND: colour = bg_index;
            mcb2rgb_pkg::CODE_VIDEO_HI:   colour = in_data.video_byte[7:4];
            mcb2rgb_pkg::CODE_VIDEO_LO:   colour = in_data.video_byte[3:0];
            default:                      colour = in_data.color_byte[3:0];
          endcase
          pixels_due.push_back(shade_pixel(colour, gain, 8'(4 * col + p),
                                           8'(8 * row + in_data.line_in_card), p == 3));
        end
      end
    end
    pending = pixels_due.size();
  end

endmodule

/* tb/multicolor_bitmap_to_rgb_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multicolor_bitmap_to_rgb_test
// feeds bitmap bytes to the multicolour decoder under several background and
// saturation settings, with random gaps and back-pressure; the checker
// predicts and compares every pixel
// ---------------------------------------------------------------------------
module multicolor_bitmap_to_rgb_test;

  localparam int CARD_COLUMNS = 40;
  localparam int CARD_ROWS    = 25;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_BYTES  = 26;
  localparam logic [mcb2rgb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [mcb2rgb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  mcb2rgb_pkg::in_item_t              in_data   = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  mcb2rgb_pkg::out_item_t             out_data;
  logic                               cfg_we    = 1'b0;
  logic [mcb2rgb_pkg::CFG_IDX_W-1:0]  cfg_index = mcb2rgb_pkg::CFG_BACKGROUND;
  logic [mcb2rgb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                               steady    = 1'b0;
  int                                 fail_count;
  int                                 pending;
  int                                 pixels_checked;
  int                                 bytes_sent = 0;

  always #5 clk = ~clk;

  multicolor_bitmap_to_rgb #(
    .CARD_COLUMNS(CARD_COLUMNS),
    .CARD_ROWS   (CARD_ROWS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  multicolor_bitmap_to_rgb_checker #(
    .CARD_COLUMNS(CARD_COLUMNS),
    .CARD_ROWS   (CARD_ROWS)
  ) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .pixels_checked(pixels_checked)
  );

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // pixel side: hold off a random number of cycles before every transaction
  initial begin : pixel_sink
    int hold;
    forever begin
      @(negedge clk);
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input mcb2rgb_pkg::in_item_t item);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  function automatic mcb2rgb_pkg::in_item_t random_byte();
    mcb2rgb_pkg::in_item_t b;
    b.pixel_byte   = 8'($urandom);
    b.video_byte   = 8'($urandom);
    b.color_byte   = 8'($urandom);
    b.card_column  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(40, 63))
                                                  : 6'($urandom_range(0, 39));
    b.card_row     = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(25, 31))
                                                  : 5'($urandom_range(0, 24));
    b.line_in_card = 3'($urandom);
    return b;
  endfunction

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mcb2rgb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mcb2rgb_pkg::CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  task automatic retune(input logic [mcb2rgb_pkg::CFG_DATA_W-1:0] bg_word,
                        input logic [mcb2rgb_pkg::CFG_DATA_W-1:0] gain_word);
    drain();
    write_reg(mcb2rgb_pkg::CFG_BACKGROUND, bg_word);
    write_reg(mcb2rgb_pkg::CFG_SATURATION, gain_word);
  endtask

  task automatic random_bytes(input int count);
    repeat (count) send_byte(random_byte());
  endtask

  initial begin : stimulus
    mcb2rgb_pkg::in_item_t b;
    int                    k;
    logic [5:0]            edge_cols [4];
    logic [4:0]            edge_rows [4];
    logic [7:0]            patterns  [5];
    edge_cols = '{6'd0, 6'd39, 6'd40, 6'd63};
    edge_rows = '{5'd0, 5'd24, 5'd25, 5'd31};
    patterns  = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hE4};

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: every colour through the video nibbles, positions at the edges
    for (k = 0; k < 8; k++) begin
      b.pixel_byte   = 8'h1B;
      b.video_byte   = {4'(2 * k), 4'(2 * k + 1)};
      b.color_byte   = {4'(15 - k), 4'(k + 8)};
      b.card_column  = edge_cols[k % 4];
      b.card_row     = edge_rows[k % 4];
      b.line_in_card = 3'(k);
      send_byte(b);
    end
    for (k = 0; k < 5; k++) begin
      b            = random_byte();
      b.pixel_byte = patterns[k];
      send_byte(b);
    end

    // widest gain, highest background index, upper data bits set
    retune(12'hFFF, 12'd4095);
    random_bytes(PHASE_BYTES);

    // no chroma at all
    retune(12'($urandom), 12'd0);
    random_bytes(PHASE_BYTES);

    // writes to unused indexes must change nothing; back-to-back traffic
    retune(12'($urandom), 12'($urandom));
    write_reg(CFG_SPARE_LO, 12'($urandom));
    write_reg(CFG_SPARE_HI, 12'($urandom));
    steady = 1'b1;
    random_bytes(PHASE_BYTES);
    drain();
    steady = 1'b0;

    retune(12'hFF0, 12'd256);
    random_bytes(PHASE_BYTES);

    retune(12'($urandom), 12'($urandom_range(0, 4095)));
    random_bytes(PHASE_BYTES);

    drain();
    $display("%0d bitmap bytes sent across six register settings, %0d pixels compared",
             bytes_sent, pixels_checked);
    if (pending != 0) $display("%0d pixels never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/mcb2rgb_pkg.sv
design/multicolor_bitmap_to_rgb.sv
tb/multicolor_bitmap_to_rgb_checker.sv
tb/multicolor_bitmap_to_rgb_test.sv
